>>> src/dbpr_pkg.sv
// Package for the rear depth budget policy ramp block.
// Holds shared widths, policy state codes, register indexes and time constants.
// Used by depth_budget_policy_ramp_core; depends on nothing.
package dbpr_pkg;

    // Level and ramp progress resolution (Q0.LEVEL_BITS).
    localparam int LEVEL_BITS = 16;
    localparam int MS_BITS    = 16;
    localparam int NS_BITS    = 36;   // ms * 1e6 for a 16-bit ms count
    localparam int LEN_BITS   = NS_BITS + LEVEL_BITS;
    localparam int CNT_BITS   = $clog2(LEN_BITS + 1);

    localparam logic [19:0] NS_PER_MS       = 20'd1000000;
    localparam logic [MS_BITS-1:0] DWELL_DEFAULT = 16'd400;
    localparam logic [MS_BITS-1:0] STALE_DEFAULT = 16'd1000;

    // Policy state codes as seen on policy_state.
    localparam logic [2:0] ST_OPAQUE    = 3'd0;
    localparam logic [2:0] ST_WORKSPACE = 3'd1;
    localparam logic [2:0] ST_OPEN      = 3'd2;
    localparam logic [2:0] ST_BUSY      = 3'd3;
    localparam logic [2:0] ST_NOSRC     = 3'd4;
    localparam logic [2:0] ST_FORCED    = 3'd5;

    // Force mode codes; the unused code behaves like automatic.
    localparam logic [1:0] FORCE_AUTO   = 2'd0;
    localparam logic [1:0] FORCE_CLIP   = 2'd1;
    localparam logic [1:0] FORCE_OPEN   = 2'd2;
    localparam logic [1:0] FORCE_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_FORCE_MODE  = 3'd0;
    localparam logic [2:0] REG_OPEN_DWELL  = 3'd1;
    localparam logic [2:0] REG_CLOSE_GRACE = 3'd2;
    localparam logic [2:0] REG_RAMP_OPEN   = 3'd3;
    localparam logic [2:0] REG_RAMP_CLOSE  = 3'd4;
    localparam logic [2:0] REG_STALE_AFTER = 3'd5;
    localparam logic [2:0] REG_FULL_SPAN   = 3'd6;

endpackage

>>> src/depth_budget_policy_ramp_core.sv
// Top level of the rear depth budget policy ramp block.
// Holds the policy decision, the ramp sequencer and the shared shift-subtract divider.
// Depends on dbpr_pkg.

// Each input beat is one update. The block chooses a policy state and a target
// level, then eases far_offset toward that target. An update takes one beat in,
// then walks a small sequencer: a policy decision state, a goal state,
// and, when a new ramp starts, a multiply and a 52-step division of the scaled ramp
// time by full_level. While a ramp is in flight, the progress fraction costs a
// 16-step division followed by the multiply states S_EASE and S_SCALE. Both
// divisions share one restoring shift-subtract unit. in_stall is high from the
// accepted beat until the result is placed in the output register. A finished
// result may wait there under out_stall while the next beat is already accepted.
// Configuration writes go through cfg_write, cfg_index and cfg_data, and are
// meant to land only while the block is idle.
module depth_budget_policy_ramp_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] now_time,
    input  logic        is_transparent,
    input  logic        workspace_owned,
    input  logic [31:0] frame_generation,
    input  logic        source_present,
    input  logic        result_present,
    input  logic        is_neutral,
    input  logic [15:0] cue_level_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] far_offset,
    output logic [2:0]  policy_state,
    output logic [15:0] cue_level_out
);

    localparam int LB = dbpr_pkg::LEVEL_BITS;
    localparam int NB = dbpr_pkg::NS_BITS;
    localparam int LN = dbpr_pkg::LEN_BITS;
    localparam int CB = dbpr_pkg::CNT_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_GOAL, S_MUL, S_DIV, S_ADV, S_EASE, S_SCALE, S_DONE
    } seq_state_t;

    // Configuration registers.
    logic [1:0]  force_mode_reg;
    logic [15:0] open_dwell_reg, close_grace_reg, ramp_open_reg, ramp_close_reg;
    logic [15:0] stale_after_reg, full_span_reg;

    // Thresholds in nanoseconds, refreshed every cycle from the registers.
    logic [NB-1:0] dwell_ns_reg, grace_ns_reg, stale_ns_reg;

    // Captured input beat.
    logic [63:0] now_reg;
    logic        transp_reg, wspace_reg, source_reg, result_reg, neutral_reg;
    logic [31:0] gen_in_reg;
    logic [15:0] cue_in_reg;

    // Policy and ramp state.
    seq_state_t  seq_reg;
    logic [2:0]  mode_reg;
    logic [LB-1:0] level_reg, origin_reg, goal_reg, span_reg;
    logic [63:0] begin_reg;
    logic [LN-1:0] len_reg;
    logic        gen_seen_reg;
    logic [31:0] gen_value_reg;
    logic [63:0] gen_time_reg;
    logic        nrun_reg, brun_reg;
    logic [63:0] nbegin_reg, bbegin_reg;
    logic [15:0] cue_held_reg;

    // Decision results carried into the ramp steps.
    logic [LB-1:0] target_reg;
    logic [15:0]   ms_reg;
    logic [NB-1:0] msns_reg;

    // Shared divider.
    logic [LN-1:0] div_rem_reg, div_num_reg, div_den_reg, div_q_reg;
    logic [CB-1:0] div_cnt_reg;
    logic          div_len_reg;
    logic [LB-1:0] prog_reg;
    logic [2*LB+1:0] sq_reg;

    logic          out_valid_reg;
    logic [15:0]   out_level_reg, out_cue_reg;
    logic [2:0]    out_state_reg;

    // Policy decision.
    logic [2:0]    nx_mode;
    logic [LB-1:0] nx_target, full_level;
    logic [15:0]   nx_ms, nx_cue;
    logic          nx_nrun, nx_brun, nx_gseen;
    logic [63:0]   nx_nbegin, nx_bbegin, nx_gtime;
    logic [31:0]   nx_gval;
    logic          gen_new;

    always_comb
    begin
        full_level = (full_span_reg == '0) ? LB'(1) : LB'(full_span_reg);
        nx_mode    = mode_reg;
        nx_target  = '0;
        nx_ms      = '0;
        nx_cue     = cue_held_reg;
        nx_nrun    = nrun_reg;
        nx_brun    = brun_reg;
        nx_nbegin  = nbegin_reg;
        nx_bbegin  = bbegin_reg;
        nx_gseen   = gen_seen_reg;
        nx_gval    = gen_value_reg;
        nx_gtime   = gen_time_reg;
        gen_new    = !gen_seen_reg || (gen_in_reg != gen_value_reg);
        if (force_mode_reg == dbpr_pkg::FORCE_CLIP)
        begin
            nx_mode = dbpr_pkg::ST_FORCED;
            nx_cue  = '0;
        end
        else if (force_mode_reg == dbpr_pkg::FORCE_OPEN)
        begin
            nx_mode   = dbpr_pkg::ST_FORCED;
            nx_target = full_level;
            nx_cue    = '0;
        end
        else if (!transp_reg || wspace_reg)
        begin
            nx_mode   = !transp_reg ? dbpr_pkg::ST_OPAQUE : dbpr_pkg::ST_WORKSPACE;
            nx_target = full_level;
            nx_cue    = '0;
            nx_nrun   = 1'b0;
            nx_brun   = 1'b0;
        end
        else
        begin
            if (gen_new)
            begin
                nx_gseen = 1'b1;
                nx_gval  = gen_in_reg;
                nx_gtime = now_reg;
            end
            // A freshly changed generation is never stalled.
            if (!source_reg || !result_reg ||
                (!gen_new && ((now_reg - gen_time_reg) > 64'(stale_ns_reg))))
            begin
                nx_mode = dbpr_pkg::ST_NOSRC;
                nx_cue  = '0;
                nx_nrun = 1'b0;
                nx_brun = 1'b0;
            end
            else if (neutral_reg)
            begin
                nx_cue  = cue_in_reg;
                nx_brun = 1'b0;
                nx_nrun = 1'b1;
                if (!nrun_reg)
                begin
                    nx_nbegin = now_reg;
                end
                if (nrun_reg && ((now_reg - nbegin_reg) >= 64'(dwell_ns_reg)))
                begin
                    nx_mode   = dbpr_pkg::ST_OPEN;
                    nx_target = full_level;
                    nx_ms     = (ramp_open_reg == '0) ? 16'd1 : ramp_open_reg;
                end
                else if (mode_reg != dbpr_pkg::ST_BUSY && mode_reg != dbpr_pkg::ST_NOSRC)
                begin
                    nx_mode = dbpr_pkg::ST_BUSY;
                end
            end
            else
            begin
                nx_cue  = cue_in_reg;
                nx_nrun = 1'b0;
                nx_brun = 1'b1;
                if (!brun_reg)
                begin
                    nx_bbegin = now_reg;
                end
                if ((brun_reg ? (now_reg - bbegin_reg) : 64'd0) >= 64'(grace_ns_reg))
                begin
                    nx_mode = dbpr_pkg::ST_BUSY;
                    nx_ms   = (ramp_close_reg == '0) ? 16'd1 : ramp_close_reg;
                end
                else
                begin
                    nx_target = goal_reg;
                end
            end
        end
        if (nx_mode != dbpr_pkg::ST_OPEN && nx_mode != dbpr_pkg::ST_BUSY)
        begin
            nx_ms = '0;
        end
    end

    // One restoring division step of the shared unit.
    logic [LN:0]   div_trial;
    logic          div_bit;
    logic [LN-1:0] div_rem_next, div_q_next;

    always_comb
    begin
        div_trial    = {div_rem_reg, div_num_reg[LN-1]};
        div_bit      = (div_trial >= {1'b0, div_den_reg});
        div_rem_next = div_bit ? LN'(div_trial - {1'b0, div_den_reg}) : LN'(div_trial);
        div_q_next   = {div_q_reg[LN-2:0], div_bit};
    end

    // Ramp helpers.
    logic [63:0]   elapsed;
    logic [LB:0]   inv_p, ease_e;
    logic [2*LB:0] scaled;
    logic [LB-1:0] span_now;

    always_comb
    begin
        elapsed  = (now_reg > begin_reg) ? (now_reg - begin_reg) : 64'd0;
        span_now = (goal_reg >= origin_reg) ? (goal_reg - origin_reg) : (origin_reg - goal_reg);
        inv_p    = (LB+1)'(1 << LB) - {1'b0, prog_reg};
        ease_e   = (LB+1)'(1 << LB) - sq_reg[2*LB:LB];
        scaled   = (2*LB+1)'(span_reg) * (2*LB+1)'(ease_e);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_mode_reg  <= '0;
            open_dwell_reg  <= 16'd400;
            close_grace_reg <= 16'd100;
            ramp_open_reg   <= 16'd300;
            ramp_close_reg  <= 16'd150;
            stale_after_reg <= 16'd1000;
            full_span_reg   <= 16'd65535;
            seq_reg         <= S_IDLE;
            mode_reg        <= dbpr_pkg::ST_NOSRC;
            level_reg       <= '0;
            origin_reg      <= '0;
            goal_reg        <= '0;
            begin_reg       <= '0;
            len_reg         <= '0;
            gen_seen_reg    <= 1'b0;
            gen_value_reg   <= '0;
            gen_time_reg    <= '0;
            nrun_reg        <= 1'b0;
            brun_reg        <= 1'b0;
            nbegin_reg      <= '0;
            bbegin_reg      <= '0;
            cue_held_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    dbpr_pkg::REG_FORCE_MODE:  force_mode_reg  <= cfg_data[1:0];
                    dbpr_pkg::REG_OPEN_DWELL:  open_dwell_reg  <= cfg_data;
                    dbpr_pkg::REG_CLOSE_GRACE: close_grace_reg <= cfg_data;
                    dbpr_pkg::REG_RAMP_OPEN:   ramp_open_reg   <= cfg_data;
                    dbpr_pkg::REG_RAMP_CLOSE:  ramp_close_reg  <= cfg_data;
                    dbpr_pkg::REG_STALE_AFTER: stale_after_reg <= cfg_data;
                    dbpr_pkg::REG_FULL_SPAN:   full_span_reg   <= cfg_data;
                    default: ;
                endcase
            end

            // A new result enters the output register as soon as the old one leaves.
            if (seq_reg == S_DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (seq_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        now_reg     <= now_time;
                        transp_reg  <= is_transparent;
                        wspace_reg  <= workspace_owned;
                        gen_in_reg  <= frame_generation;
                        source_reg  <= source_present;
                        result_reg  <= result_present;
                        neutral_reg <= is_neutral;
                        cue_in_reg  <= cue_level_in;
                        seq_reg     <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    mode_reg      <= nx_mode;
                    target_reg    <= nx_target;
                    ms_reg        <= nx_ms;
                    cue_held_reg  <= nx_cue;
                    nrun_reg      <= nx_nrun;
                    brun_reg      <= nx_brun;
                    nbegin_reg    <= nx_nbegin;
                    bbegin_reg    <= nx_bbegin;
                    gen_seen_reg  <= nx_gseen;
                    gen_value_reg <= nx_gval;
                    gen_time_reg  <= nx_gtime;
                    seq_reg       <= S_GOAL;
                end
                S_GOAL:
                begin
                    seq_reg <= S_ADV;
                    if (goal_reg != target_reg)
                    begin
                        origin_reg <= level_reg;
                        goal_reg   <= target_reg;
                        begin_reg  <= now_reg;
                        span_reg   <= (target_reg > level_reg) ? (target_reg - level_reg)
                                                               : (level_reg - target_reg);
                        if (ms_reg == '0)
                        begin
                            len_reg   <= '0;
                            level_reg <= target_reg;
                        end
                        else
                        begin
                            msns_reg <= NB'(ms_reg) * NB'(dbpr_pkg::NS_PER_MS);
                            seq_reg  <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    // Scaled ramp length: ms * 1e6 * span / full span.
                    div_num_reg <= LN'(msns_reg) * LN'(span_reg);
                    div_rem_reg <= '0;
                    div_den_reg <= LN'(full_level);
                    div_q_reg   <= '0;
                    div_cnt_reg <= CB'(LN);
                    div_len_reg <= 1'b1;
                    seq_reg     <= S_DIV;
                end
                S_DIV:
                begin
                    div_rem_reg <= div_rem_next;
                    div_num_reg <= {div_num_reg[LN-2:0], 1'b0};
                    div_q_reg   <= div_q_next;
                    div_cnt_reg <= div_cnt_reg - CB'(1);
                    if (div_cnt_reg == CB'(1))
                    begin
                        if (div_len_reg)
                        begin
                            len_reg <= (div_q_next == '0) ? LN'(1) : div_q_next;
                            seq_reg <= S_ADV;
                        end
                        else
                        begin
                            prog_reg <= div_q_next[LB-1:0];
                            seq_reg  <= S_EASE;
                        end
                    end
                end
                S_ADV:
                begin
                    span_reg <= span_now;
                    if (len_reg == '0)
                    begin
                        level_reg <= goal_reg;
                        seq_reg   <= S_DONE;
                    end
                    else if (elapsed >= 64'(len_reg))
                    begin
                        level_reg <= goal_reg;
                        len_reg   <= '0;
                        seq_reg   <= S_DONE;
                    end
                    else
                    begin
                        // Progress fraction: elapsed / len in Q0.LEVEL_BITS.
                        div_rem_reg <= LN'(elapsed);
                        div_num_reg <= '0;
                        div_den_reg <= len_reg;
                        div_q_reg   <= '0;
                        div_cnt_reg <= CB'(LB);
                        div_len_reg <= 1'b0;
                        seq_reg     <= S_DIV;
                    end
                end
                S_EASE:
                begin
                    sq_reg  <= (2*LB+2)'(inv_p) * (2*LB+2)'(inv_p);
                    seq_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    // The step is truncated toward the origin in both directions.
                    if (goal_reg >= origin_reg)
                    begin
                        level_reg <= origin_reg + scaled[2*LB-1:LB];
                    end
                    else
                    begin
                        level_reg <= origin_reg - scaled[2*LB-1:LB];
                    end
                    seq_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_level_reg <= 16'(level_reg);
                        out_state_reg <= mode_reg;
                        out_cue_reg   <= cue_held_reg;
                        seq_reg       <= S_IDLE;
                    end
                end
                default: seq_reg <= S_IDLE;
            endcase
        end
    end

    // Thresholds in nanoseconds; zero dwell and zero stale time take their defaults.
    always_ff @(posedge clk)
    begin
        dwell_ns_reg <= NB'((open_dwell_reg == '0) ? dbpr_pkg::DWELL_DEFAULT : open_dwell_reg)
                        * NB'(dbpr_pkg::NS_PER_MS);
        grace_ns_reg <= NB'(close_grace_reg) * NB'(dbpr_pkg::NS_PER_MS);
        stale_ns_reg <= NB'((stale_after_reg == '0) ? dbpr_pkg::STALE_DEFAULT : stale_after_reg)
                        * NB'(dbpr_pkg::NS_PER_MS);
    end

    assign in_stall      = (seq_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign far_offset    = out_level_reg;
    assign policy_state  = out_state_reg;
    assign cue_level_out = out_cue_reg;

endmodule
